/* rtl/core/error_diffusion_dither_defines.svh */
// ----------------------------------------------------------------------------
// error_diffusion_dither_defines
// Assertion helpers for the error diffusion dither block.
// ----------------------------------------------------------------------------
// Every check is clocked on the rising edge of clk and is off while arst_n is low.
`ifndef ERROR_DIFFUSION_DITHER_DEFINES_SVH
`define ERROR_DIFFUSION_DITHER_DEFINES_SVH

// Same-cycle implication.
`define EDD_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define EDD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/edd_pkg.sv */
// ----------------------------------------------------------------------------
// edd_pkg
// Shared constants and types of the error diffusion dither block.
// ----------------------------------------------------------------------------
`default_nettype none

package edd_pkg;

	// Pixel channel level width.
	localparam int LEVEL_W = 8;
	// Line length register width and its reset value.
	localparam int LEN_W = 11;
	localparam logic [LEN_W-1:0] LEN_RESET = 11'd1024;
	// Default storage and error word sizes.
	localparam int MAX_LINE_DEF = 1024;
	localparam int ERROR_BITS_DEF = 14;
	// One lane per color channel.
	localparam int NUM_LANES = 3;

	// Per-pixel control handed to every channel lane.
	typedef struct packed {
		logic step;   // pixel leaves the compute stage this cycle
		logic clear;  // frame start: row carries read as zero
		logic first;  // first row of the frame: store reads as zero
		logic last;   // last column of the row
	} lane_ctl_t;

endpackage

`default_nettype wire

/* rtl/core/edd_pixel_if.sv */
// ----------------------------------------------------------------------------
// edd_pixel_if
// Valid/ready channel carrying one RGB pixel request.
// ----------------------------------------------------------------------------
`default_nettype none

interface edd_pixel_if;
	import edd_pkg::*;

	logic               valid;
	logic               ready;
	logic [LEVEL_W-1:0] red_level;
	logic [LEVEL_W-1:0] green_level;
	logic [LEVEL_W-1:0] blue_level;
	logic               frame_start;

	modport source (
		output valid, red_level, green_level, blue_level, frame_start,
		input  ready
	);
	modport sink (
		input  valid, red_level, green_level, blue_level, frame_start,
		output ready
	);
endinterface

`default_nettype wire

/* rtl/core/edd_bits_if.sv */
// ----------------------------------------------------------------------------
// edd_bits_if
// Valid/ready channel carrying one dithered pixel request.
// ----------------------------------------------------------------------------
`default_nettype none

interface edd_bits_if;
	logic valid;
	logic ready;
	logic red_bit;
	logic green_bit;
	logic blue_bit;

	modport source (
		output valid, red_bit, green_bit, blue_bit,
		input  ready
	);
	modport sink (
		input  valid, red_bit, green_bit, blue_bit,
		output ready
	);
endinterface

`default_nettype wire

/* rtl/core/edd_lane.sv */
// ----------------------------------------------------------------------------
// edd_lane
// One color channel: threshold, quantization error and its split into shares.
// ----------------------------------------------------------------------------
`default_nettype none

module edd_lane #(
	parameter int ERROR_BITS = edd_pkg::ERROR_BITS_DEF
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire  edd_pkg::lane_ctl_t            ctl,
	input  wire  [edd_pkg::LEVEL_W-1:0]         level,
	input  wire  signed [ERROR_BITS-1:0]        store_err,
	output logic                                dot,
	output logic signed [ERROR_BITS-1:0]        left_entry,
	output logic signed [ERROR_BITS-1:0]        own_entry
);
	import edd_pkg::*;

	localparam int EB = ERROR_BITS;
	localparam int XW = EB + 4;
	localparam logic signed [XW-1:0] SAT_HI = {{(XW-EB+1){1'b0}}, {(EB-1){1'b1}}};
	localparam logic signed [XW-1:0] SAT_LO = {{(XW-EB+1){1'b1}}, {(EB-1){1'b0}}};
	localparam logic signed [XW-1:0] MIDPOINT = XW'(2048);
	localparam logic signed [XW-1:0] FULL_SCALE = XW'(4080);

	function automatic logic signed [EB-1:0] sat(input logic signed [XW-1:0] x);
		logic signed [EB-1:0] r;
		if (x > SAT_HI) begin
			r = SAT_HI[EB-1:0];
		end else if (x < SAT_LO) begin
			r = SAT_LO[EB-1:0];
		end else begin
			r = x[EB-1:0];
		end
		return r;
	endfunction

	// Row carries: right neighbor share, pending entries for columns c-1 and c.
	logic signed [EB-1:0] right_q, lp_left_q, lp_own_q;

	logic signed [EB-1:0] st_err, rc, lp_left, lp_own, owed;
	logic signed [XW-1:0] lev16, e, q, q3, q5, s1, s3, s5, s7;
	logic signed [EB-1:0] lp_left_nx, lp_own_nx, right_nx;

	// Owed error and threshold.
	always_comb begin
		st_err  = ctl.first ? '0 : store_err;
		rc      = ctl.clear ? '0 : right_q;
		lp_left = ctl.clear ? '0 : lp_left_q;
		lp_own  = ctl.clear ? '0 : lp_own_q;
		owed    = sat(XW'(st_err) + XW'(rc));
		lev16   = XW'({level, 4'b0000});
		e       = lev16 + XW'(owed);
		dot     = (e >= MIDPOINT);
		q       = dot ? (e - FULL_SCALE) : e;
	end

	// Shares in 1/16 steps, floored; the right share takes the remainder.
	always_comb begin
		q3 = (q <<< 1) + q;
		q5 = (q <<< 2) + q;
		s3 = q3 >>> 4;
		s5 = q5 >>> 4;
		s1 = q >>> 4;
		s7 = q - s3 - s5 - s1;
		left_entry = sat(XW'(lp_left) + s3);
		lp_left_nx = sat(XW'(lp_own) + s5);
		lp_own_nx  = sat(s1);
		right_nx   = sat(s7);
		own_entry  = lp_left_nx;
	end

	// Carry update; the end of a row drops everything still owed along it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			right_q   <= '0;
			lp_left_q <= '0;
			lp_own_q  <= '0;
		end else if (ctl.step) begin
			if (ctl.last) begin
				right_q   <= '0;
				lp_left_q <= '0;
				lp_own_q  <= '0;
			end else begin
				right_q   <= right_nx;
				lp_left_q <= lp_left_nx;
				lp_own_q  <= lp_own_nx;
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/core/edd_line_store.sv */
// ----------------------------------------------------------------------------
// edd_line_store
// Next-row error memory with a deferred write slot and read forwarding.
// ----------------------------------------------------------------------------
`default_nettype none

module edd_line_store #(
	parameter int MAX_LINE   = edd_pkg::MAX_LINE_DEF,
	parameter int ERROR_BITS = edd_pkg::ERROR_BITS_DEF,
	localparam int AW = $clog2(MAX_LINE),
	localparam int DW = edd_pkg::NUM_LANES * ERROR_BITS
) (
	input  wire           clk,
	input  wire           arst_n,
	input  wire           rd_en,
	input  wire  [AW-1:0] rd_addr,
	input  wire           wr_en,
	input  wire  [AW-1:0] wr_addr,
	input  wire  [DW-1:0] wr_data,
	input  wire           defer_en,
	input  wire  [AW-1:0] defer_addr,
	input  wire  [DW-1:0] defer_data,
	output logic [DW-1:0] rd_data
);
	import edd_pkg::*;

	logic [DW-1:0] mem [MAX_LINE];
	logic [DW-1:0] mem_q;

	logic          pend_q;
	logic [AW-1:0] pend_addr_q;
	logic [DW-1:0] pend_data_q;

	logic [AW-1:0] held_addr_q;
	logic          snoop_hit_q;
	logic [DW-1:0] snoop_data_q;

	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [DW-1:0] mem_wdata;

	// Single write port: direct write first, the deferred entry otherwise.
	always_comb begin
		mem_we    = wr_en || pend_q;
		mem_waddr = wr_en ? wr_addr : pend_addr_q;
		mem_wdata = wr_en ? wr_data : pend_data_q;
	end

	// Memory array, registered read.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (rd_en) begin
			mem_q <= mem[rd_addr];
		end
	end

	// Deferred write slot for the last column's own entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
		end else if (defer_en) begin
			pend_q <= 1'b1;
		end else if (!wr_en) begin
			pend_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (defer_en) begin
			pend_addr_q <= defer_addr;
			pend_data_q <= defer_data;
		end
	end

	// Catch writes to the held address that the registered read missed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			snoop_hit_q <= 1'b0;
		end else if (rd_en) begin
			snoop_hit_q <= mem_we && (mem_waddr == rd_addr);
		end else if (mem_we && (mem_waddr == held_addr_q)) begin
			snoop_hit_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			held_addr_q <= rd_addr;
		end
		if (mem_we && (rd_en ? (mem_waddr == rd_addr) : (mem_waddr == held_addr_q))) begin
			snoop_data_q <= mem_wdata;
		end
	end

	// Newest copy wins: deferred slot, then snooped write, then the array.
	always_comb begin
		if (pend_q && (pend_addr_q == held_addr_q)) begin
			rd_data = pend_data_q;
		end else if (snoop_hit_q) begin
			rd_data = snoop_data_q;
		end else begin
			rd_data = mem_q;
		end
	end

endmodule

`default_nettype wire

/* rtl/core/error_diffusion_dither.sv */
// ----------------------------------------------------------------------------
// error_diffusion_dither
// Floyd-Steinberg dither of an RGB raster stream down to one bit per channel.
// ----------------------------------------------------------------------------
// Takes one pixel request per clock while the output side is ready and returns
// one dithered request per pixel, passing through stage 1 and the output register.
// The rate is set by the per-channel right-neighbor error loop, closing inside
// each lane, and by the line store's single write port, shared with a one-entry
// deferred write at the end of a multi-column row. Three lanes (red, green, blue)
// run side by side; their shares are merged into one store word per column.
// The store needs no clearing pass: the first row of each frame ignores it.
// line_length may be written only while no pixel is in flight; 0 acts as 1 and
// values above MAX_LINE act as MAX_LINE.
`default_nettype none

`include "error_diffusion_dither_defines.svh"

module error_diffusion_dither #(
	parameter int MAX_LINE   = edd_pkg::MAX_LINE_DEF,
	parameter int ERROR_BITS = edd_pkg::ERROR_BITS_DEF
) (
	input  wire                        clk,
	input  wire                        arst_n,
	edd_pixel_if.sink                  pixel,
	edd_bits_if.source                 result,
	input  wire                        cfg_write,
	input  wire  [edd_pkg::LEN_W-1:0]  cfg_data
);
	import edd_pkg::*;

	localparam int CW   = $clog2(MAX_LINE);
	localparam int LW   = CW + 1;
	localparam int CMPW = (LW > LEN_W) ? LW : LEN_W;
	localparam int EB   = ERROR_BITS;
	localparam int DW   = NUM_LANES * EB;

	// Configuration register.
	logic [LEN_W-1:0] line_length_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_length_q <= LEN_RESET;
		end else if (cfg_write) begin
			line_length_q <= cfg_data;
		end
	end

	// Effective line length and last column.
	logic [CMPW-1:0] len_ext, len_clamp;
	logic [CW-1:0]   last_col;

	always_comb begin
		len_ext = CMPW'(line_length_q);
		if (len_ext == '0) begin
			len_clamp = CMPW'(1);
		end else if (len_ext > CMPW'(MAX_LINE)) begin
			len_clamp = CMPW'(MAX_LINE);
		end else begin
			len_clamp = len_ext;
		end
		last_col = CW'(len_clamp - CMPW'(1));
	end

	// Handshake and pipeline control.
	logic valid_s1, out_valid_q, advance, accept;

	assign advance     = valid_s1 && (!out_valid_q || result.ready);
	assign pixel.ready = !valid_s1 || advance;
	assign accept      = pixel.valid && pixel.ready;

	// Column tracking at acceptance.
	logic [CW-1:0] col_count_q, col_cur, col_sel;
	logic          first_row_q, first_cur, is_last;

	always_comb begin
		col_cur   = pixel.frame_start ? '0 : col_count_q;
		first_cur = pixel.frame_start ? 1'b1 : first_row_q;
		is_last   = (col_cur >= last_col);
		col_sel   = is_last ? last_col : col_cur;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_count_q <= '0;
			first_row_q <= 1'b1;
		end else if (accept) begin
			col_count_q <= is_last ? '0 : (col_sel + CW'(1));
			first_row_q <= is_last ? 1'b0 : first_cur;
		end
	end

	// Stage 1: pixel held while its store entry is read.
	logic [NUM_LANES-1:0][LEVEL_W-1:0] level_s1;
	logic [CW-1:0]                     col_s1;
	logic                              last_s1, first_s1, fs_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			level_s1 <= {pixel.blue_level, pixel.green_level, pixel.red_level};
			col_s1   <= col_sel;
			last_s1  <= is_last;
			first_s1 <= first_cur;
			fs_s1    <= pixel.frame_start;
		end
	end

	// Channel lanes.
	lane_ctl_t      lane_ctl;
	logic [DW-1:0]  store_rd, left_word, own_word;
	logic [NUM_LANES-1:0] lane_dot;

	assign lane_ctl = '{step: advance, clear: fs_s1, first: first_s1, last: last_s1};

	for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
		edd_lane #(
			.ERROR_BITS (ERROR_BITS)
		) u_lane (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (lane_ctl),
			.level      (level_s1[i]),
			.store_err  (store_rd[i*EB +: EB]),
			.dot        (lane_dot[i]),
			.left_entry (left_word[i*EB +: EB]),
			.own_entry  (own_word[i*EB +: EB])
		);
	end

	// Merge lane shares into store writes.
	logic          st_we, st_defer, col_nz;
	logic [CW-1:0] st_waddr;
	logic [DW-1:0] st_wdata;

	always_comb begin
		col_nz   = (col_s1 != '0);
		st_we    = advance && (col_nz || last_s1);
		st_waddr = col_nz ? (col_s1 - CW'(1)) : col_s1;
		st_wdata = col_nz ? left_word : own_word;
		st_defer = advance && last_s1 && col_nz;
	end

	edd_line_store #(
		.MAX_LINE   (MAX_LINE),
		.ERROR_BITS (ERROR_BITS)
	) u_store (
		.clk        (clk),
		.arst_n     (arst_n),
		.rd_en      (accept),
		.rd_addr    (col_sel),
		.wr_en      (st_we),
		.wr_addr    (st_waddr),
		.wr_data    (st_wdata),
		.defer_en   (st_defer),
		.defer_addr (col_s1),
		.defer_data (own_word),
		.rd_data    (store_rd)
	);

	// Output register.
	logic [NUM_LANES-1:0] dot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			dot_q <= lane_dot;
		end
	end

	assign result.valid     = out_valid_q;
	assign result.red_bit   = dot_q[0];
	assign result.green_bit = dot_q[1];
	assign result.blue_bit  = dot_q[2];

	// Checks.
	`EDD_ASSERT_NEXT(a_row_wrap, accept && is_last, col_count_q == '0, "column not reset after last column")
	`EDD_ASSERT_NEXT(a_advance_out, advance, out_valid_q, "advanced pixel missing at output")
	`EDD_ASSERT_NEXT(a_hold_s1, valid_s1 && !advance, valid_s1, "stalled pixel dropped")
	`EDD_ASSERT_SAME(a_col_range, valid_s1, col_s1 <= last_col, "pixel column beyond row")

endmodule

`default_nettype wire

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the error diffusion dither block.
// ----------------------------------------------------------------------------
// Pixel requests go in through the pixel channel, and the dithered bits come
// back through the result channel. A bit-exact Floyd-Steinberg model runs
// beside the block. It keeps its own line store, right carry, below partials,
// column and first-row flag, and it queues the bits due for each accepted
// pixel.
//
// The run has three parts:
//   - a short directed table: extremes, midpoint edges, one-pixel rows,
//     out-of-range lengths and a length that shrinks mid-row;
//   - random phases, each at its own line length, including one at the
//     maximum length;
//   - random stalls on both sides, one long hold on the result side, and a
//     full drain before every length change.
// A pixel that would read a store entry never written is turned into a
// frame start.
`default_nettype none

module tb;
	import edd_pkg::*;

	localparam int LINE_MAX    = MAX_LINE_DEF;
	localparam int ERR_W       = ERROR_BITS_DEF;
	localparam int ERR_MAX     = (1 << (ERR_W - 1)) - 1;
	localparam int ERR_MIN     = -(1 << (ERR_W - 1));
	localparam int MIDPOINT    = 2048;   // 128 in 1/16 steps
	localparam int FULL_SCALE  = 4080;   // 255 in 1/16 steps
	localparam int SETTLE      = 8;      // cycles past the last result
	localparam int HOLD_CYCLES = 60;     // long result-side hold
	localparam int QUIET_LIMIT = 2000;   // cycles with no request moving
	localparam int RAND_PIXELS = 600;

	typedef logic signed [ERR_W-1:0] err_t;

	typedef struct packed {
		logic red;
		logic green;
		logic blue;
	} dither_bits_t;

	// One directed step: a length write, or a pixel with optional known bits.
	typedef struct packed {
		logic             set_len;
		logic [LEN_W-1:0] len;
		logic             fs;
		logic [7:0]       r;
		logic [7:0]       g;
		logic [7:0]       b;
		logic             known;
		logic [2:0]       bits;  // red, green, blue
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic cfg_write;
	logic [LEN_W-1:0] cfg_data;

	edd_pixel_if pix ();
	edd_bits_if  res ();

	error_diffusion_dither dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pixel     (pix),
		.result    (res),
		.cfg_write (cfg_write),
		.cfg_data  (cfg_data)
	);

	// Model state
	err_t             row_debt [LINE_MAX][NUM_LANES];
	bit               row_written [LINE_MAX];
	err_t             carry_right [NUM_LANES];
	err_t             below_pending [2][NUM_LANES];
	int               col_next = 0;
	bit               in_first_row = 1'b1;
	logic [LEN_W-1:0] line_len_reg = LEN_RESET;

	dither_bits_t bits_due [$];

	// Side information for the pixel currently offered
	bit           cur_known;
	dither_bits_t cur_bits;

	// Run control and tallies
	bit src_gaps = 1'b1;
	bit sink_stalls = 1'b1;
	bit hold_output = 1'b0;
	int mismatches = 0;
	int pixels_sent = 0;
	int bits_checked = 0;
	int frame_starts = 0;
	int len_writes = 0;
	int holds_done = 0;

	stim_row_t directed_rows [29] = '{
		// line length at its reset value
		'{1'b0, 11'd0,    1'b1, 8'd255, 8'd0,   8'd128, 1'b1, 3'b101},
		'{1'b0, 11'd0,    1'b1, 8'd127, 8'd128, 8'd0,   1'b1, 3'b010},
		'{1'b0, 11'd0,    1'b1, 8'd0,   8'd0,   8'd0,   1'b1, 3'b000},
		'{1'b0, 11'd0,    1'b0, 8'd0,   8'd0,   8'd0,   1'b1, 3'b000},
		'{1'b0, 11'd0,    1'b0, 8'd255, 8'd255, 8'd255, 1'b1, 3'b111},
		'{1'b0, 11'd0,    1'b0, 8'd255, 8'd255, 8'd255, 1'b1, 3'b111},
		'{1'b0, 11'd0,    1'b0, 8'd128, 8'd127, 8'd200, 1'b0, 3'b000},
		'{1'b0, 11'd0,    1'b0, 8'd1,   8'd254, 8'd60,  1'b0, 3'b000},
		// one-pixel rows: every pixel is the last column
		'{1'b1, 11'd1,    1'b0, 8'd0,   8'd0,   8'd0,   1'b0, 3'b000},
		'{1'b0, 11'd0,    1'b1, 8'd200, 8'd100, 8'd50,  1'b1, 3'b100},
		'{1'b0, 11'd0,    1'b0, 8'd200, 8'd100, 8'd50,  1'b0, 3'b000},
		'{1'b0, 11'd0,    1'b0, 8'd0,   8'd255, 8'd128, 1'b0, 3'b000},
		// zero length behaves as one
		'{1'b1, 11'd0,    1'b0, 8'd0,   8'd0,   8'd0,   1'b0, 3'b000},
		'{1'b0, 11'd0,    1'b0, 8'd127, 8'd128, 8'd129, 1'b0, 3'b000},
		'{1'b0, 11'd0,    1'b0, 8'd64,  8'd192, 8'd10,  1'b0, 3'b000},
		// short rows, second row reads the store
		'{1'b1, 11'd3,    1'b0, 8'd0,   8'd0,   8'd0,   1'b0, 3'b000},
		'{1'b0, 11'd0,    1'b1, 8'd100, 8'd150, 8'd250, 1'b1, 3'b011},
		'{1'b0, 11'd0,    1'b0, 8'd100, 8'd150, 8'd250, 1'b0, 3'b000},
		'{1'b0, 11'd0,    1'b0, 8'd100, 8'd150, 8'd250, 1'b0, 3'b000},
		'{1'b0, 11'd0,    1'b0, 8'd0,   8'd255, 8'd128, 1'b0, 3'b000},
		'{1'b0, 11'd0,    1'b0, 8'd255, 8'd0,   8'd127, 1'b0, 3'b000},
		'{1'b0, 11'd0,    1'b0, 8'd128, 8'd128, 8'd128, 1'b0, 3'b000},
		// length above the store size clamps to it
		'{1'b1, 11'd2047, 1'b0, 8'd0,   8'd0,   8'd0,   1'b0, 3'b000},
		'{1'b0, 11'd0,    1'b1, 8'd255, 8'd255, 8'd0,   1'b1, 3'b110},
		'{1'b0, 11'd0,    1'b0, 8'd0,   8'd0,   8'd255, 1'b0, 3'b000},
		// shrink mid-row: column past the end acts as the last one
		'{1'b1, 11'd2,    1'b0, 8'd0,   8'd0,   8'd0,   1'b0, 3'b000},
		'{1'b0, 11'd0,    1'b0, 8'd90,  8'd90,  8'd90,  1'b0, 3'b000},
		'{1'b0, 11'd0,    1'b0, 8'd170, 8'd30,  8'd240, 1'b0, 3'b000},
		'{1'b0, 11'd0,    1'b0, 8'd33,  8'd222, 8'd129, 1'b0, 3'b000}
	};

	function automatic int clamp_err(input int x);
		if (x > ERR_MAX) return ERR_MAX;
		if (x < ERR_MIN) return ERR_MIN;
		return x;
	endfunction

	function automatic int eff_line_len();
		if (line_len_reg == 0) return 1;
		if (line_len_reg > LINE_MAX) return LINE_MAX;
		return int'(line_len_reg);
	endfunction

	function automatic void clear_row_carries();
		for (int ch = 0; ch < NUM_LANES; ch++) begin
			carry_right[ch] = '0;
			below_pending[0][ch] = '0;
			below_pending[1][ch] = '0;
		end
	endfunction

	// Dither one pixel and advance the row/line state; lane 0 is red.
	function automatic dither_bits_t dither_pixel(input logic fs,
			input logic [NUM_LANES-1:0][LEVEL_W-1:0] lvl);
		int len, col, owed, e, q, s1, s3, s5, s7;
		logic last;
		logic [NUM_LANES-1:0] lane_bits;
		len = eff_line_len();
		if (fs) begin
			col_next = 0;
			in_first_row = 1'b1;
			clear_row_carries();
		end
		last = (col_next >= len - 1);
		col = last ? len - 1 : col_next;
		for (int ch = 0; ch < NUM_LANES; ch++) begin
			owed = in_first_row ? 0 : int'(row_debt[col][ch]);
			owed = clamp_err(owed + carry_right[ch]);
			e = int'(lvl[ch]) * 16 + owed;
			lane_bits[ch] = (e >= MIDPOINT);
			q = e - (lane_bits[ch] ? FULL_SCALE : 0);
			// floor shares; the right share takes the remainder
			s3 = (q * 3) >>> 4;
			s5 = (q * 5) >>> 4;
			s1 = q >>> 4;
			s7 = clamp_err(q - s3 - s5 - s1);
			s3 = clamp_err(s3);
			s5 = clamp_err(s5);
			s1 = clamp_err(s1);
			if (col > 0) begin
				row_debt[col-1][ch] = clamp_err(below_pending[0][ch] + s3);
				row_written[col-1] = 1'b1;
			end
			below_pending[0][ch] = clamp_err(below_pending[1][ch] + s5);
			below_pending[1][ch] = s1;
			carry_right[ch] = s7;
			if (last) begin
				row_debt[col][ch] = below_pending[0][ch];
				row_written[col] = 1'b1;
			end
		end
		if (last) begin
			clear_row_carries();
			col_next = 0;
			in_first_row = 1'b0;
		end else begin
			col_next = col + 1;
		end
		return '{red: lane_bits[0], green: lane_bits[1], blue: lane_bits[2]};
	endfunction

	task automatic report_mismatch(input string field, input logic want, input logic got);
		mismatches++;
		$display("[%0t] mismatch on %s of result %0d: want %0b, got %0b",
			$time, field, bits_checked, want, got);
	endtask

	// Clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Scoreboard: check results, then model newly accepted pixels
	always @(posedge clk) begin : scoreboard
		dither_bits_t got, want;
		if (arst_n) begin
			if (cfg_write)
				line_len_reg = cfg_data;
			if (res.valid && res.ready) begin
				got = '{red: res.red_bit, green: res.green_bit, blue: res.blue_bit};
				if (bits_due.size() == 0) begin
					// a result with no pixel outstanding
					report_mismatch("valid", 1'b0, 1'b1);
				end else begin
					want = bits_due.pop_front();
					if (got.red !== want.red)
						report_mismatch("red_bit", want.red, got.red);
					if (got.green !== want.green)
						report_mismatch("green_bit", want.green, got.green);
					if (got.blue !== want.blue)
						report_mismatch("blue_bit", want.blue, got.blue);
				end
				bits_checked++;
			end
			if (pix.valid && pix.ready) begin
				want = dither_pixel(pix.frame_start,
					{pix.blue_level, pix.green_level, pix.red_level});
				bits_due.insert(bits_due.size(), cur_known ? cur_bits : want);
				if (pix.frame_start)
					frame_starts++;
			end
		end
	end

	// Result side: random ready gaps, plus one long hold on request
	initial begin : result_sink
		int gap;
		res.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_output) begin
				res.ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_output = 1'b0;
				holds_done++;
			end
			if ($urandom_range(0, 39) == 0)
				sink_stalls = !sink_stalls;
			gap = sink_stalls ? $urandom_range(0, 8) : 0;
			if (gap > 0) begin
				res.ready = 1'b0;
				repeat (gap) @(negedge clk);
			end
			res.ready = 1'b1;
			do @(posedge clk); while (!res.valid);
		end
	end

	// No request moving for too long ends the run
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((pix.valid && pix.ready) || (res.valid && res.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("timeout: no request moved for %0d cycles, %0d results outstanding",
			QUIET_LIMIT, bits_due.size());
		$display("== FAIL ==");
		$finish;
	end

	// Offer one pixel after a random gap, wait for its acceptance
	task automatic send_pixel(input logic fs, input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b, input bit known, input dither_bits_t bits);
		int gap, len, col;
		gap = src_gaps ? $urandom_range(0, 8) : 0;
		@(negedge clk);
		if (gap > 0) begin
			pix.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		// never read a store entry that no row has written yet
		len = eff_line_len();
		col = (col_next >= len - 1) ? len - 1 : col_next;
		if (!fs && !in_first_row && !row_written[col])
			fs = 1'b1;
		pix.frame_start = fs;
		pix.red_level = r;
		pix.green_level = g;
		pix.blue_level = b;
		cur_known = known;
		cur_bits = bits;
		pix.valid = 1'b1;
		do @(posedge clk); while (!pix.ready);
		pixels_sent++;
	endtask

	// Stop offering and wait until every pixel has its result back
	task automatic drain_results();
		@(negedge clk);
		pix.valid = 1'b0;
		while (bits_due.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_line_length(input logic [LEN_W-1:0] len);
		drain_results();
		@(negedge clk);
		cfg_write = 1'b1;
		cfg_data = len;
		@(negedge clk);
		cfg_write = 1'b0;
		len_writes++;
	endtask

	function automatic logic [7:0] pick_level();
		case ($urandom_range(0, 9))
			0: return 8'd0;
			1: return 8'd255;
			2: return 8'($urandom_range(127, 128));
			3: return 8'($urandom_range(120, 136));
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// Stimulus
	initial begin : stimulus
		int rand_pixels, phase, n;
		logic [LEN_W-1:0] len;
		logic fs;
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_data = '0;
		pix.valid = 1'b0;
		pix.frame_start = 1'b0;
		pix.red_level = '0;
		pix.green_level = '0;
		pix.blue_level = '0;
		cur_known = 1'b0;
		cur_bits = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed table
		foreach (directed_rows[i]) begin
			if (directed_rows[i].set_len)
				write_line_length(directed_rows[i].len);
			else
				send_pixel(directed_rows[i].fs, directed_rows[i].r, directed_rows[i].g,
					directed_rows[i].b, directed_rows[i].known,
					dither_bits_t'(directed_rows[i].bits));
		end

		// random phases, each at one line length
		rand_pixels = 0;
		phase = 0;
		while (rand_pixels < RAND_PIXELS) begin
			if (phase == 2) begin
				// largest length that needs no clamping
				len = 11'(LINE_MAX);
			end else begin
				case ($urandom_range(0, 9))
					0: len = 11'($urandom_range(0, 2));
					1: len = ($urandom_range(0, 1) != 0) ? 11'd2047 : 11'(LINE_MAX + 1);
					2: len = 11'($urandom_range(17, 80));
					default: len = 11'($urandom_range(3, 16));
				endcase
			end
			n = $urandom_range(10, 60);
			write_line_length(len);
			src_gaps = ($urandom_range(0, 3) != 0);
			if (phase == 4) begin
				// sender keeps offering while the result side holds off
				n = 80;
				src_gaps = 1'b0;
				hold_output = 1'b1;
			end
			for (int i = 0; i < n; i++) begin
				fs = (i == 0 && $urandom_range(0, 1) != 0) || ($urandom_range(0, 49) == 0);
				send_pixel(fs, pick_level(), pick_level(), pick_level(), 1'b0, '0);
			end
			rand_pixels += n;
			phase++;
		end

		drain_results();
		$display("sent %0d pixels (%0d frame starts) over %0d line length writes",
			pixels_sent, frame_starts, len_writes);
		$display("compared %0d results, %0d long result holds, %0d mismatches",
			bits_checked, holds_done, mismatches);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

`default_nettype wire
